// ===== rtl/rrwt_pkg.sv =====
package rrwt_pkg;

    // item and result widths
    localparam int SEQ_W   = 32;
    localparam int SIZE_W  = 16;
    localparam int BYTES_W = 48;

    // window and bitmap geometry (bitmap depth is a power of two, at least one word)
    localparam int REORDER_WINDOW = 256;
    localparam int BITMAP_DEPTH   = 512;
    localparam int WORD_W         = 32;
    localparam int NUM_WORDS      = BITMAP_DEPTH / WORD_W;
    localparam int SLOT_W         = $clog2(BITMAP_DEPTH);
    localparam int OFS_W          = $clog2(WORD_W);
    localparam int ADDR_W         = $clog2(NUM_WORDS);
    localparam int CNT_W          = $clog2(BITMAP_DEPTH + 1);
    localparam int RUN_W          = $clog2(WORD_W + 1);

    // event kind
    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_TRIM = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_SET_RD,
        ST_SET_WR,
        ST_SCAN_RD,
        ST_SCAN_WR,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic eval;
        logic rd_set;
        logic wr_set;
        logic rd_scan;
        logic wr_scan;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_data;
        logic err;
        logic seq_eq;
        logic seq_gt;
        logic scan_done;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/rrwt_ctrl.sv =====
module rrwt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  rrwt_pkg::t_sts  i_sts,
    output rrwt_pkg::t_cmd  o_cmd
);

    rrwt_pkg::t_state r_state;
    rrwt_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrwt_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrwt_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) n_state = rrwt_pkg::ST_IDLE;
            end
            rrwt_pkg::ST_IDLE: begin
                if (i_valid) n_state = rrwt_pkg::ST_EVAL;
            end
            rrwt_pkg::ST_EVAL: begin
                if (!i_sts.is_data || i_sts.err) begin
                    n_state = rrwt_pkg::ST_DONE;
                end else if (i_sts.seq_eq) begin
                    n_state = rrwt_pkg::ST_SCAN_RD;
                end else if (i_sts.seq_gt) begin
                    n_state = rrwt_pkg::ST_SET_RD;
                end else begin
                    n_state = rrwt_pkg::ST_DONE;
                end
            end
            rrwt_pkg::ST_SET_RD:  n_state = rrwt_pkg::ST_SET_WR;
            rrwt_pkg::ST_SET_WR:  n_state = rrwt_pkg::ST_DONE;
            rrwt_pkg::ST_SCAN_RD: n_state = rrwt_pkg::ST_SCAN_WR;
            rrwt_pkg::ST_SCAN_WR: begin
                n_state = i_sts.scan_done ? rrwt_pkg::ST_DONE : rrwt_pkg::ST_SCAN_RD;
            end
            rrwt_pkg::ST_DONE: begin
                if (!i_sts.out_busy) n_state = rrwt_pkg::ST_IDLE;
            end
            default: n_state = rrwt_pkg::ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            rrwt_pkg::ST_CLEAR:   o_cmd.clr_step = 1'b1;
            rrwt_pkg::ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            rrwt_pkg::ST_EVAL:    o_cmd.eval    = 1'b1;
            rrwt_pkg::ST_SET_RD:  o_cmd.rd_set  = 1'b1;
            rrwt_pkg::ST_SET_WR:  o_cmd.wr_set  = 1'b1;
            rrwt_pkg::ST_SCAN_RD: o_cmd.rd_scan = 1'b1;
            rrwt_pkg::ST_SCAN_WR: o_cmd.wr_scan = 1'b1;
            rrwt_pkg::ST_DONE:    o_cmd.out_load = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

    // the clearing pass runs only once after reset
    a_no_reclear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rrwt_pkg::ST_CLEAR) |=> (r_state != rrwt_pkg::ST_CLEAR))
        else $error("bitmap clear pass restarted without reset");

    // a partial scan always fetches the next bitmap word
    a_scan_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wr_scan && !i_sts.scan_done) |=> o_cmd.rd_scan)
        else $error("advance scan stopped early");

    // a result is produced for every accepted word before the next is taken
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == rrwt_pkg::ST_IDLE))
        else $error("result load did not return to idle");

endmodule

// ===== rtl/rrwt_dp.sv =====
module rrwt_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrwt_pkg::t_cmd                i_cmd,
    output rrwt_pkg::t_sts                o_sts,
    input  logic                          i_func,
    input  logic [rrwt_pkg::SEQ_W-1:0]    i_seq_num,
    input  logic [rrwt_pkg::SIZE_W-1:0]   i_size_bytes,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [rrwt_pkg::SEQ_W-1:0]    o_next_expected,
    output logic [rrwt_pkg::SEQ_W-1:0]    o_highest_seen,
    output logic [rrwt_pkg::BYTES_W-1:0]  o_total_bytes,
    output logic                          o_window_error
);

    // count of consecutive ones from bit 0 upward
    function automatic logic [rrwt_pkg::RUN_W-1:0] trailing_ones(
        input logic [rrwt_pkg::WORD_W-1:0] x
    );
        logic [rrwt_pkg::RUN_W-1:0] n;
        n = rrwt_pkg::RUN_W'(rrwt_pkg::WORD_W);
        for (int i = rrwt_pkg::WORD_W - 1; i >= 0; i--) begin
            if (!x[i]) n = rrwt_pkg::RUN_W'(i);
        end
        return n;
    endfunction

    // ones in the low n bits
    function automatic logic [rrwt_pkg::WORD_W-1:0] low_mask(
        input logic [rrwt_pkg::RUN_W-1:0] n
    );
        logic [rrwt_pkg::WORD_W-1:0] m;
        for (int i = 0; i < rrwt_pkg::WORD_W; i++) begin
            m[i] = (rrwt_pkg::RUN_W'(i) < n);
        end
        return m;
    endfunction

    function automatic logic w_gt_high(
        input logic [rrwt_pkg::SEQ_W-1:0] a,
        input logic [rrwt_pkg::SEQ_W-1:0] b
    );
        return a > b;
    endfunction

    // held item
    logic                          r_func;
    logic [rrwt_pkg::SEQ_W-1:0]    r_seq;
    logic [rrwt_pkg::SIZE_W-1:0]   r_size;

    // tracker state
    logic [rrwt_pkg::SEQ_W-1:0]    r_exp;
    logic [rrwt_pkg::SEQ_W-1:0]    r_high;
    logic [rrwt_pkg::BYTES_W-1:0]  r_total;
    logic                          r_err;

    // advance scan
    logic [rrwt_pkg::SEQ_W-1:0]    r_q;
    logic [rrwt_pkg::CNT_W-1:0]    r_cnt;

    // bitmap memory
    logic [rrwt_pkg::WORD_W-1:0]   r_mem [rrwt_pkg::NUM_WORDS];
    logic [rrwt_pkg::WORD_W-1:0]   r_rdata;
    logic [rrwt_pkg::ADDR_W-1:0]   r_clr_addr;

    // result register
    logic                          r_out_valid;
    logic [rrwt_pkg::SEQ_W-1:0]    r_out_exp;
    logic [rrwt_pkg::SEQ_W-1:0]    r_out_high;
    logic [rrwt_pkg::BYTES_W-1:0]  r_out_total;
    logic                          r_out_err;

    logic [rrwt_pkg::SEQ_W:0]      w_limit;
    logic                          w_is_data;
    logic                          w_err;
    logic                          w_eq;
    logic                          w_gt;
    logic [rrwt_pkg::BYTES_W:0]    w_sum;
    logic [rrwt_pkg::BYTES_W-1:0]  n_total;
    logic [rrwt_pkg::SEQ_W-1:0]    n_high;

    logic [rrwt_pkg::OFS_W-1:0]    w_ofs;
    logic [rrwt_pkg::RUN_W-1:0]    w_ofs_x;
    logic [rrwt_pkg::WORD_W-1:0]   w_shift;
    logic [rrwt_pkg::RUN_W-1:0]    w_run;
    logic [rrwt_pkg::CNT_W-1:0]    w_rem;
    logic [rrwt_pkg::RUN_W-1:0]    w_take;
    logic [rrwt_pkg::RUN_W-1:0]    w_room;
    logic [rrwt_pkg::WORD_W-1:0]   w_mask;
    logic [rrwt_pkg::WORD_W-1:0]   n_word;
    logic [rrwt_pkg::CNT_W-1:0]    n_cnt;
    logic [rrwt_pkg::SEQ_W-1:0]    n_q;
    logic                          w_cap;
    logic                          w_scan_done;

    logic [rrwt_pkg::ADDR_W-1:0]   w_seq_addr;
    logic [rrwt_pkg::ADDR_W-1:0]   w_q_addr;
    logic [rrwt_pkg::WORD_W-1:0]   w_set_word;
    logic                          w_we;
    logic [rrwt_pkg::ADDR_W-1:0]   w_waddr;
    logic [rrwt_pkg::WORD_W-1:0]   w_wdata;
    logic                          w_re;
    logic [rrwt_pkg::ADDR_W-1:0]   w_raddr;
    logic                          w_out_busy;

    // window check and compares
    assign w_limit   = {1'b0, r_exp} + (rrwt_pkg::SEQ_W + 1)'(rrwt_pkg::REORDER_WINDOW);
    assign w_is_data = (r_func == rrwt_pkg::FUNC_DATA);
    assign w_err     = w_is_data && ({1'b0, r_seq} > w_limit);
    assign w_eq      = (r_seq == r_exp);
    assign w_gt      = (r_seq > r_exp);

    // saturating byte total and highest number seen
    assign w_sum   = {1'b0, r_total} + (rrwt_pkg::BYTES_W + 1)'(r_size);
    assign n_total = w_sum[rrwt_pkg::BYTES_W] ? '1 : w_sum[rrwt_pkg::BYTES_W-1:0];
    assign n_high  = w_gt_high(r_seq, r_high) ? r_seq : r_high;

    // word-wide scan step: run of set bits from the current slot upward
    assign w_ofs       = r_q[rrwt_pkg::OFS_W-1:0];
    assign w_ofs_x     = rrwt_pkg::RUN_W'(w_ofs);
    assign w_shift     = r_rdata >> w_ofs;
    assign w_run       = trailing_ones(w_shift);
    assign w_rem       = rrwt_pkg::CNT_W'(rrwt_pkg::BITMAP_DEPTH) - r_cnt;
    assign w_take      = (rrwt_pkg::CNT_W'(w_run) > w_rem) ? w_rem[rrwt_pkg::RUN_W-1:0] : w_run;
    assign w_room      = rrwt_pkg::RUN_W'(rrwt_pkg::WORD_W) - w_ofs_x;
    assign w_mask      = low_mask(w_ofs_x + w_take) & ~low_mask(w_ofs_x);
    assign n_word      = r_rdata & ~w_mask;
    assign n_cnt       = r_cnt + rrwt_pkg::CNT_W'(w_take);
    assign n_q         = r_q + rrwt_pkg::SEQ_W'(w_take);
    assign w_cap       = (n_cnt == rrwt_pkg::CNT_W'(rrwt_pkg::BITMAP_DEPTH));
    assign w_scan_done = (w_take != w_room) || w_cap;

    // bitmap addressing
    assign w_seq_addr = r_seq[rrwt_pkg::SLOT_W-1:rrwt_pkg::OFS_W];
    assign w_q_addr   = r_q[rrwt_pkg::SLOT_W-1:rrwt_pkg::OFS_W];
    assign w_set_word = r_rdata | (rrwt_pkg::WORD_W'(1) << r_seq[rrwt_pkg::OFS_W-1:0]);

    assign w_we    = i_cmd.clr_step || i_cmd.wr_set || i_cmd.wr_scan;
    assign w_waddr = i_cmd.clr_step ? r_clr_addr : (i_cmd.wr_set ? w_seq_addr : w_q_addr);
    assign w_wdata = i_cmd.clr_step ? '0 : (i_cmd.wr_set ? w_set_word : n_word);
    assign w_re    = i_cmd.rd_set || i_cmd.rd_scan;
    assign w_raddr = i_cmd.rd_set ? w_seq_addr : w_q_addr;

    // bitmap write port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // bitmap read port
    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + rrwt_pkg::ADDR_W'(1);
        end
    end

    // held item word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_seq  <= i_seq_num;
            r_size <= i_size_bytes;
        end
    end

    // tracker state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp   <= '0;
            r_high  <= '0;
            r_total <= '0;
            r_err   <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_err <= w_err;
                if (!w_err) r_high <= n_high;
                if (w_is_data && !w_err) r_total <= n_total;
            end
            if (i_cmd.wr_scan && w_scan_done) begin
                r_exp <= w_cap ? (n_q - rrwt_pkg::SEQ_W'(1)) : n_q;
            end
        end
    end

    // scan pointer and cleared-bit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.eval && w_is_data && !w_err && w_eq) begin
            r_cnt <= '0;
        end else if (i_cmd.wr_scan) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_q <= r_exp + rrwt_pkg::SEQ_W'(1);
        end else if (i_cmd.wr_scan) begin
            r_q <= n_q;
        end
    end

    // result register
    assign w_out_busy = r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_exp   <= r_exp;
            r_out_high  <= r_high;
            r_out_total <= r_total;
            r_out_err   <= r_err;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_next_expected = r_out_exp;
    assign o_highest_seen  = r_out_high;
    assign o_total_bytes   = r_out_total;
    assign o_window_error  = r_out_err;

    // status to controller
    always_comb begin
        o_sts           = '0;
        o_sts.clr_last  = (r_clr_addr == rrwt_pkg::ADDR_W'(rrwt_pkg::NUM_WORDS - 1));
        o_sts.is_data   = w_is_data;
        o_sts.err       = w_err;
        o_sts.seq_eq    = w_eq;
        o_sts.seq_gt    = w_gt;
        o_sts.scan_done = w_scan_done;
        o_sts.out_busy  = w_out_busy;
    end

    // the scan never clears more bits than the bitmap holds
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= rrwt_pkg::CNT_W'(rrwt_pkg::BITMAP_DEPTH))
        else $error("advance scan count past bitmap depth");

    // the expected number moves only at the end of an advance scan
    a_exp_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_exp != $past(r_exp))) |-> $past(i_cmd.wr_scan && w_scan_done))
        else $error("expected number changed outside advance scan");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && i_stall))
        else $error("result register overwritten while stalled");

endmodule

// ===== rtl/receive_reorder_window_tracker_core.sv =====
// channel   direction  handshake            payload
// item      in         i_valid / o_stall    i_func, i_seq_num, i_size_bytes
// result    out        o_valid / i_stall    o_next_expected, o_highest_seen,
//                                           o_total_bytes, o_window_error
//
// a trimmed word, a window error or a stale number goes from evaluation
// to the result step; a new out-of-order number adds a read-modify-write of
// its bitmap word; an in-order number adds a read and a write of each 32-bit
// bitmap word the advance touches. the bitmap memory has a write port and a
// registered read port. after reset a pass clears the 16 bitmap words (one
// bitmap word per cycle) before the first word is taken; reset is synchronous
// and active low.
// the result sits in its own register, so a stalled result does not block
// acceptance of the next item word; that word waits in its last step instead.
module receive_reorder_window_tracker_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [rrwt_pkg::SEQ_W-1:0]    i_seq_num,
    input  logic [rrwt_pkg::SIZE_W-1:0]   i_size_bytes,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rrwt_pkg::SEQ_W-1:0]    o_next_expected,
    output logic [rrwt_pkg::SEQ_W-1:0]    o_highest_seen,
    output logic [rrwt_pkg::BYTES_W-1:0]  o_total_bytes,
    output logic                          o_window_error
);

    rrwt_pkg::t_cmd w_cmd;
    rrwt_pkg::t_sts w_sts;

    // sequencing
    rrwt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // tracker state, bitmap and result register
    rrwt_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_func          (i_func),
        .i_seq_num       (i_seq_num),
        .i_size_bytes    (i_size_bytes),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_next_expected (o_next_expected),
        .o_highest_seen  (o_highest_seen),
        .o_total_bytes   (o_total_bytes),
        .o_window_error  (o_window_error)
    );

endmodule
